/* sv/hcbp_pkg.sv */
// Shared types and constants for the code bit packer.
package hcbp_pkg;

   localparam int CODE_W   = 32;   // width of the code field on the request channel
   localparam int LEN_W    = 6;    // width of a code length
   localparam int SYM_W    = 8;    // width of a symbol
   localparam int BYTE_W   = 8;
   localparam int VBITS_W  = 4;
   localparam int WORD_W   = 40;   // pending byte plus one full-width code
   localparam int BITS_W   = 6;    // holds up to 39 buffered bits
   localparam int Q_DEPTH  = 4;
   localparam int Q_PTR_W  = 2;
   localparam int Q_CNT_W  = 3;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FLUSH  = 2'd2
   } req_kind_type;

   // One work entry handed from the front end to the packer.
   typedef struct packed {
      logic              is_flush;
      logic [CODE_W-1:0] code_left;   // code bits, left aligned
      logic [LEN_W-1:0]  code_len;
   } work_entry_type;

endpackage

/* sv/hcbp_if.sv */
// Request and response channel interfaces of the code bit packer.
interface hcbp_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      req_type;
   logic [hcbp_pkg::SYM_W-1:0]      symbol;
   logic [hcbp_pkg::CODE_W-1:0]     code_bits;
   logic [hcbp_pkg::LEN_W-1:0]      code_length;

   modport source (output valid, req_type, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, req_type, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [hcbp_pkg::BYTE_W-1:0]     packed_byte;
   logic [hcbp_pkg::VBITS_W-1:0]    valid_bits;
   logic                            last_of_run;

   modport source (output valid, packed_byte, valid_bits, last_of_run, input ready);
   modport sink   (input valid, packed_byte, valid_bits, last_of_run, output ready);
endinterface

/* sv/hcbp_front.sv */
// Front end: accepts items, owns the code table and classifies work for the packer.
module hcbp_front #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   hcbp_req_if.sink                  req_chan,
   output logic                      push_valid,
   output hcbp_pkg::work_entry_type  push_entry,
   input  logic                      push_ready
);

   localparam int AddrW    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int CodeW    = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;
   localparam logic [hcbp_pkg::LEN_W-1:0] LenLimit = hcbp_pkg::LEN_W'(CodeW);

   logic [CodeW-1:0]           code_mem [SYMBOL_COUNT];
   logic [hcbp_pkg::LEN_W-1:0] len_mem  [SYMBOL_COUNT];

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_flush_ff;
   logic [CodeW-1:0]           code_rd_ff;
   logic [hcbp_pkg::LEN_W-1:0] len_rd_ff;

   logic                       accept;
   logic                       in_range;
   logic                       advance;
   logic                       is_load, is_encode, is_flush;
   logic [AddrW-1:0]           addr;
   logic [hcbp_pkg::LEN_W-1:0] sat_len;
   logic [hcbp_pkg::CODE_W-1:0] len_mask;
   logic [hcbp_pkg::CODE_W-1:0] masked_code;

   assign in_range = {1'b0, req_chan.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
   assign addr     = req_chan.symbol[AddrW-1:0];

   always_comb begin
      is_load   = 1'b0;
      is_encode = 1'b0;
      is_flush  = 1'b0;
      unique case (req_chan.req_type)
         hcbp_pkg::REQ_LOAD:   is_load   = 1'b1;
         hcbp_pkg::REQ_ENCODE: is_encode = 1'b1;
         hcbp_pkg::REQ_FLUSH:  is_flush  = 1'b1;
         default: ;
      endcase
   end

   // A zero-length encode contributes nothing, so it never enters the queue.
   assign push_valid = s1_valid_ff && (s1_flush_ff || (len_rd_ff != '0));
   assign advance    = !s1_valid_ff || !push_valid || push_ready;
   assign req_chan.ready = advance;
   assign accept     = req_chan.valid && advance;

   assign sat_len     = (req_chan.code_length > LenLimit) ? LenLimit : req_chan.code_length;
   assign len_mask    = ~({hcbp_pkg::CODE_W{1'b1}} << sat_len);
   assign masked_code = req_chan.code_bits & len_mask;

   // Out-of-range encodes act as zero-length codes and are dropped here.
   assign s1_valid_in = accept && ((is_encode && in_range) || is_flush);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flush_ff <= is_flush;
      end
      if (accept && is_encode && in_range) begin
         code_rd_ff <= code_mem[addr];
         len_rd_ff  <= len_mem[addr];
      end
      if (accept && is_load && in_range) begin
         code_mem[addr] <= CodeW'(masked_code);
         len_mem[addr]  <= sat_len;
      end
   end

   always_comb begin
      push_entry.is_flush  = s1_flush_ff;
      push_entry.code_len  = len_rd_ff;
      push_entry.code_left = hcbp_pkg::CODE_W'(code_rd_ff)
                             << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - len_rd_ff);
   end

endmodule

/* sv/hcbp_queue.sv */
// Short queue of work entries between the front end and the packer.
module hcbp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  hcbp_pkg::work_entry_type  push_entry,
   output logic                      push_ready,
   output logic                      pop_valid,
   output hcbp_pkg::work_entry_type  pop_entry,
   input  logic                      pop_ready
);

   hcbp_pkg::work_entry_type          slot_ff [hcbp_pkg::Q_DEPTH];
   logic [hcbp_pkg::Q_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [hcbp_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   logic                              do_push, do_pop;

   assign push_ready = count_ff != hcbp_pkg::Q_CNT_W'(hcbp_pkg::Q_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/hcbp_back.sv */
// Back end: merges codes into the bit buffer and emits bytes through an output register.
module hcbp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   input  hcbp_pkg::work_entry_type  pop_entry,
   output logic                      pop_ready,
   hcbp_rsp_if.source                rsp_chan
);

   // The buffer is left aligned; bits below the count are always zero.
   logic [hcbp_pkg::WORD_W-1:0]  word_ff, word_in;
   logic [hcbp_pkg::BITS_W-1:0]  bits_ff, bits_in;

   logic                         out_valid_ff;
   logic [hcbp_pkg::BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic [hcbp_pkg::VBITS_W-1:0] out_vbits_ff, out_vbits_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_load;
   logic                         out_free;
   logic [hcbp_pkg::WORD_W-1:0]  merged;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign merged   = {word_ff[hcbp_pkg::WORD_W-1 -: hcbp_pkg::BYTE_W],
                      {hcbp_pkg::CODE_W{1'b0}}}
                   | ({pop_entry.code_left, {hcbp_pkg::BYTE_W{1'b0}}} >> bits_ff[2:0]);

   always_comb begin
      word_in      = word_ff;
      bits_in      = bits_ff;
      pop_ready    = 1'b0;
      out_load     = 1'b0;
      out_byte_in  = word_ff[hcbp_pkg::WORD_W-1 -: hcbp_pkg::BYTE_W];
      out_vbits_in = hcbp_pkg::VBITS_W'(hcbp_pkg::BYTE_W);
      out_last_in  = 1'b0;
      priority if (bits_ff >= hcbp_pkg::BITS_W'(hcbp_pkg::BYTE_W)) begin
         if (out_free) begin
            out_load    = 1'b1;
            out_last_in = bits_ff < hcbp_pkg::BITS_W'(2 * hcbp_pkg::BYTE_W);
            word_in     = word_ff << hcbp_pkg::BYTE_W;
            bits_in     = bits_ff - hcbp_pkg::BITS_W'(hcbp_pkg::BYTE_W);
         end
      end else if (pop_valid && pop_entry.is_flush) begin
         if (bits_ff == '0) begin
            pop_ready = 1'b1;
         end else if (out_free) begin
            pop_ready    = 1'b1;
            out_load     = 1'b1;
            out_vbits_in = {1'b0, bits_ff[2:0]};
            out_last_in  = 1'b1;
            word_in      = '0;
            bits_in      = '0;
         end
      end else if (pop_valid) begin
         pop_ready = 1'b1;
         word_in   = merged;
         bits_in   = bits_ff + pop_entry.code_len;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= '0;
         bits_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         word_ff <= word_in;
         bits_ff <= bits_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff  <= out_byte_in;
         out_vbits_ff <= out_vbits_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.packed_byte = out_byte_ff;
   assign rsp_chan.valid_bits  = out_vbits_ff;
   assign rsp_chan.last_of_run = out_last_ff;

endmodule

/* sv/huffman_code_bit_packer_unit.sv */
// Top level of the code bit packer: front end, work queue and byte packer.
// The first byte of an encode item passes the table read register, the work queue, the
// merge into the bit buffer and the output register before it reaches the response channel.
// The front end takes one item per cycle while the queue can take its work; the packer
// pops no new item while its bit buffer holds a full byte still to be emitted.
// Reset clears the bit buffer, the queue and all valid flags; the code table is not cleared.
module huffman_code_bit_packer_unit #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   hcbp_req_if.sink    req_chan,
   hcbp_rsp_if.source  rsp_chan
);

   logic                      push_valid, push_ready;
   hcbp_pkg::work_entry_type  push_entry;
   logic                      pop_valid, pop_ready;
   hcbp_pkg::work_entry_type  pop_entry;

   hcbp_front #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   hcbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   hcbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

   // A partial byte only comes from a flush, which always ends its item.
   a_partial_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.valid_bits != 4'd8) |-> rsp_chan.last_of_run)
      else $error("partial byte without last_of_run");

   a_bits_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.valid_bits != 4'd0) && (rsp_chan.valid_bits <= 4'd8))
      else $error("valid_bits out of range");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

   a_flush_entry_empty: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready && !pop_entry.is_flush |-> pop_entry.code_len != '0)
      else $error("zero-length code reached the packer");

endmodule

/* tb/hcbp_byte_monitor.sv */
// Channel monitor for the code bit packer: predicts every output byte and compares it.
`timescale 1ns / 100ps
module hcbp_byte_monitor #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic clock,
   input  logic reset,
   hcbp_req_if  req_chan,
   hcbp_rsp_if  rsp_chan,
   output int   fail_count,
   output int   outstanding
);

   localparam int LEN_LIMIT =
      (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;

   typedef struct packed {
      logic [hcbp_pkg::BYTE_W-1:0]  packed_byte;
      logic [hcbp_pkg::VBITS_W-1:0] valid_bits;
      logic                         last_of_run;
   } out_byte_type;

   out_byte_type                expected_bytes[$];
   logic [hcbp_pkg::CODE_W-1:0] code_table[SYMBOL_COUNT];
   logic [hcbp_pkg::LEN_W-1:0]  length_table[SYMBOL_COUNT];
   logic [6:0]                  held_bits;
   int unsigned                 held_count;

   function automatic logic [63:0] low_bits(input int unsigned n);
      return (64'd1 << n) - 64'd1;
   endfunction

   task automatic predict_bytes(input logic [1:0] kind,
                                input logic [hcbp_pkg::SYM_W-1:0] sym,
                                input logic [hcbp_pkg::CODE_W-1:0] bits,
                                input logic [hcbp_pkg::LEN_W-1:0] len);
      int unsigned  clen;
      int unsigned  total;
      int unsigned  nbytes;
      int unsigned  k;
      logic [63:0]  acc;
      out_byte_type ob;
      unique case (kind)
         hcbp_pkg::REQ_LOAD: begin
            if (sym < SYMBOL_COUNT) begin
               clen = (len > LEN_LIMIT) ? LEN_LIMIT : len;
               code_table[sym]   = bits & hcbp_pkg::CODE_W'(low_bits(clen));
               length_table[sym] = hcbp_pkg::LEN_W'(clen);
            end
         end
         hcbp_pkg::REQ_ENCODE: begin
            clen = 0;
            acc  = '0;
            // A symbol outside the table behaves like a code of length zero.
            if (sym < SYMBOL_COUNT) begin
               clen = length_table[sym];
               acc  = 64'(code_table[sym]);
            end
            acc    = (64'(held_bits) << clen) | acc;
            total  = held_count + clen;
            nbytes = (total / 8 > 4) ? 4 : total / 8;
            for (k = 0; k < nbytes; k++) begin
               ob.packed_byte = hcbp_pkg::BYTE_W'(acc >> (total - 8 * (k + 1)));
               ob.valid_bits  = hcbp_pkg::VBITS_W'(8);
               ob.last_of_run = (k == nbytes - 1);
               expected_bytes.push_back(ob);
            end
            total      = total - 8 * nbytes;
            held_bits  = 7'(acc & low_bits(total));
            held_count = total;
         end
         hcbp_pkg::REQ_FLUSH: begin
            if (held_count != 0) begin
               ob.packed_byte = hcbp_pkg::BYTE_W'({1'b0, held_bits} << (8 - held_count));
               ob.valid_bits  = hcbp_pkg::VBITS_W'(held_count);
               ob.last_of_run = 1'b1;
               expected_bytes.push_back(ob);
               held_bits  = '0;
               held_count = 0;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      out_byte_type seen;
      out_byte_type want;
      if (reset) begin
         held_bits  = '0;
         held_count = 0;
         fail_count = 0;
         expected_bytes.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_bytes(req_chan.req_type, req_chan.symbol, req_chan.code_bits,
                          req_chan.code_length);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.packed_byte = rsp_chan.packed_byte;
            seen.valid_bits  = rsp_chan.valid_bits;
            seen.last_of_run = rsp_chan.last_of_run;
            if (expected_bytes.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected byte %h valid_bits %0d last %b", $realtime,
                           seen.packed_byte, seen.valid_bits, seen.last_of_run);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (seen.packed_byte !== want.packed_byte || seen.valid_bits !== want.valid_bits
                   || seen.last_of_run !== want.last_of_run) begin
                  if (fail_count < 10)
                     $display("%0t: byte mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                              $realtime, want.packed_byte, want.valid_bits, want.last_of_run,
                              seen.packed_byte, seen.valid_bits, seen.last_of_run);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_bytes.size();
   end

endmodule

/* tb/tb_huffman_code_bit_packer_unit.sv */
// Stimulus, handshake pacing and final verdict for the code bit packer.
`timescale 1ns / 100ps
module tb_huffman_code_bit_packer_unit;

   localparam int         SYMBOL_COUNT = 256;
   localparam int         MAX_CODE_LEN = 32;
   localparam int         PHASE_ITEMS  = 150;
   localparam logic [1:0] REQ_UNKNOWN  = 2'd3;

   logic                       clock;
   logic                       reset;
   int                         fail_count;
   int                         outstanding;
   int                         send_idle_pct;
   int                         rsp_idle_pct;
   bit                         is_loaded[SYMBOL_COUNT];
   logic [hcbp_pkg::SYM_W-1:0] loaded_syms[$];

   hcbp_req_if req_chan();
   hcbp_rsp_if rsp_chan();

   huffman_code_bit_packer_unit #(
      .SYMBOL_COUNT(SYMBOL_COUNT),
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   hcbp_byte_monitor #(
      .SYMBOL_COUNT(SYMBOL_COUNT),
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) byte_monitor (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_request(input logic [1:0] kind, input logic [hcbp_pkg::SYM_W-1:0] sym,
                               input logic [hcbp_pkg::CODE_W-1:0] bits,
                               input logic [hcbp_pkg::LEN_W-1:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= kind;
      req_chan.symbol      <= sym;
      req_chan.code_bits   <= bits;
      req_chan.code_length <= len;
      do
         @(posedge clock);
      while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic load_code(input logic [hcbp_pkg::SYM_W-1:0] sym,
                            input logic [hcbp_pkg::CODE_W-1:0] bits,
                            input logic [hcbp_pkg::LEN_W-1:0] len);
      send_request(hcbp_pkg::REQ_LOAD, sym, bits, len);
      if (!is_loaded[sym]) begin
         is_loaded[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
   endtask

   task automatic encode_symbol(input logic [hcbp_pkg::SYM_W-1:0] sym);
      send_request(hcbp_pkg::REQ_ENCODE, sym, $urandom(), hcbp_pkg::LEN_W'($urandom()));
   endtask

   task automatic flush_bits();
      send_request(hcbp_pkg::REQ_FLUSH, hcbp_pkg::SYM_W'($urandom()), $urandom(),
                   hcbp_pkg::LEN_W'($urandom()));
   endtask

   task automatic idle_until_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // Mostly encodes of loaded symbols, with loads, flushes and a few ignored requests.
   task automatic run_phase(input int send_pct, input int rsp_pct, input int item_count);
      int                         done_items;
      int                         pick;
      logic [hcbp_pkg::SYM_W-1:0] sym;
      logic [hcbp_pkg::LEN_W-1:0] len;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      done_items    = 0;
      while (done_items < item_count) begin
         pick = $urandom_range(99);
         if (pick < 14) begin
            sym  = hcbp_pkg::SYM_W'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 6)
               len = '0;
            else if (pick < 72)
               len = hcbp_pkg::LEN_W'($urandom_range(10, 1));
            else if (pick < 96)
               len = hcbp_pkg::LEN_W'($urandom_range(32, 11));
            else
               len = hcbp_pkg::LEN_W'($urandom_range(63, 33));
            load_code(sym, $urandom(), len);
            done_items++;
         end else if (pick < 86) begin
            encode_symbol(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
            done_items++;
         end else if (pick < 97) begin
            flush_bits();
            done_items++;
         end else begin
            send_request(REQ_UNKNOWN, hcbp_pkg::SYM_W'($urandom()), $urandom(),
                         hcbp_pkg::LEN_W'($urandom()));
         end
      end
      idle_until_drained();
   endtask

   initial begin
      int wait_cycles;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = hcbp_pkg::REQ_LOAD;
      req_chan.symbol      = '0;
      req_chan.code_bits   = '0;
      req_chan.code_length = '0;
      send_idle_pct        = 24;
      rsp_idle_pct         = 61;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty flush, ignored request, extreme and saturated code lengths.
      flush_bits();
      send_request(REQ_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      load_code(8'h00, 32'hFFFF_FFFF, 6'd32);
      load_code(8'hFF, 32'hFFFF_FFFF, 6'd0);
      load_code(8'h01, 32'hAAAA_AAA5, 6'd3);
      load_code(8'h80, 32'h8000_0001, 6'd40);
      load_code(8'h7F, 32'h5555_5555, 6'd63);
      load_code(8'h02, 32'h0000_00A5, 6'd8);
      load_code(8'h03, 32'hFFFF_FF7F, 6'd7);
      encode_symbol(8'h00);
      encode_symbol(8'h02);
      flush_bits();
      encode_symbol(8'hFF);
      encode_symbol(8'h01);
      flush_bits();
      encode_symbol(8'h03);
      encode_symbol(8'h80);
      encode_symbol(8'h7F);
      encode_symbol(8'h00);
      send_request(REQ_UNKNOWN, 8'h01, 32'h0000_0000, 6'd0);
      encode_symbol(8'h01);
      flush_bits();
      encode_symbol(8'h03);
      flush_bits();

      // The sender holds off here until every predicted byte has been seen.
      idle_until_drained();

      run_phase(24, 61, PHASE_ITEMS);
      run_phase(61, 24, PHASE_ITEMS);
      run_phase(0, 0, PHASE_ITEMS);

      wait_cycles = 0;
      while (outstanding != 0 && wait_cycles < 2000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (40) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_400_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
